FILE: rtl/prle_pkg.sv
// prle_pkg: shared types and constants for the pixel rle packet encoder
// holds the sequencer state enum, the result and store request structs
// depends on nothing; imported by every other rtl file
`default_nettype none

package prle_pkg;

    // width of the packet counter: holds up to a full literal plus the lookahead pixel
    localparam int CNT_W = 8;
    localparam int PIX_W = 32;
    // pixel fields in one result on the port side
    localparam int NUM_PIX = 4;
    localparam logic [7:0] HDR_RUN = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_END,
        ST_LIT_RD,
        ST_LIT_PUSH
    } state_t;

    typedef struct packed {
        logic                           has_header;
        logic [7:0]                     header;
        logic [2:0]                     pixel_count;
        logic [NUM_PIX-1:0][PIX_W-1:0]  pix;
        logic                           row_done;
        logic                           step_last;
    } result_t;

    typedef struct packed {
        logic               wr_en;
        logic [CNT_W-1:0]   wr_addr;
        logic [PIX_W-1:0]   wr_data;
        logic               rd_en;
        logic [CNT_W-1:0]   rd_addr;
    } store_req_t;

    // low bytes kept for a given width code; zero acts as one, above four as four
    function automatic logic [PIX_W-1:0] pixel_mask(input logic [2:0] bpp);
        logic [PIX_W-1:0] m;
        unique case (bpp)
            3'd0, 3'd1: m = 32'h0000_00FF;
            3'd2:       m = 32'h0000_FFFF;
            3'd3:       m = 32'h00FF_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/prle_store.sv
// prle_store: literal pixel memory, one write and one registered read port
// depends on prle_pkg for the store request struct
`default_nettype none

module prle_store
    import prle_pkg::*;
#(
    parameter int MAX_PACKET = 128
) (
    input  wire logic               clk,
    input  wire store_req_t         req,
    output logic [PIX_W-1:0]        rd_data
);

    localparam int AW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;

    logic [PIX_W-1:0] mem [MAX_PACKET];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/prle_outreg.sv
// prle_outreg: output register between the sequencer and the result channel
// depends on prle_pkg for the result struct
`default_nettype none

module prle_outreg
    import prle_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire result_t            push_res,
    output logic                    free,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output result_t                 res
);

    logic    valid_reg;
    result_t res_reg;

    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: rtl/prle_ctrl.sv
// prle_ctrl: packet sequencer; holds the open packet state and walks the literal store
// depends on prle_pkg; drives prle_store and prle_outreg
`default_nettype none

module prle_ctrl
    import prle_pkg::*;
#(
    parameter int MAX_PACKET        = 128,
    parameter int PIXELS_PER_RESULT = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [2:0]         bpp,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [PIX_W-1:0]   pixel,
    input  wire logic               row_end,
    output store_req_t              sreq,
    input  wire logic [PIX_W-1:0]   rd_data,
    input  wire logic               out_free,
    output logic                    push,
    output result_t                 push_res
);

    localparam int SW = (PIXELS_PER_RESULT > 1) ? $clog2(PIXELS_PER_RESULT) : 1;
    localparam logic [CNT_W-1:0] MAX_C  = CNT_W'(MAX_PACKET);
    localparam logic [SW-1:0]    SLOT_L = SW'(PIXELS_PER_RESULT - 1);

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [PIX_W-1:0]   x_reg, x_next;
    logic               end_reg, end_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               run_reg, run_next;
    logic [PIX_W-1:0]   held_reg, held_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               first_reg, first_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic               done_reg, done_next;
    logic               last_reg, last_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [SW-1:0]      rd_slot_reg, rd_slot_next;
    logic [PIX_W-1:0]   build_reg [PIXELS_PER_RESULT];

    logic [CNT_W-1:0]   lit;
    logic               eq;
    state_t             after_step;
    logic               emit_go;
    logic [CNT_W-1:0]   emit_n;
    logic               emit_done;
    logic               emit_last;
    state_t             emit_ret;
    logic               last_chunk;
    logic [CNT_W-1:0]   n_m1;
    logic [CNT_W-1:0]   cnt_m1;

    assign in_stall   = (state_reg != ST_IDLE);
    assign lit        = count_reg - CNT_W'(1);
    assign eq         = (x_reg == held_reg);
    assign after_step = end_reg ? ST_END : ST_IDLE;
    assign last_chunk = (pos_reg == n_reg);
    assign n_m1       = n_reg - CNT_W'(1);
    assign cnt_m1     = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        x_next       = x_reg;
        end_next     = end_reg;
        count_next   = count_reg;
        run_next     = run_reg;
        held_next    = held_reg;
        n_next       = n_reg;
        pos_next     = pos_reg;
        first_next   = first_reg;
        slot_next    = slot_reg;
        done_next    = done_reg;
        last_next    = last_reg;
        rd_vld_next  = 1'b0;
        rd_slot_next = rd_slot_reg;
        sreq         = '0;
        push         = 1'b0;
        push_res     = '0;
        emit_go      = 1'b0;
        emit_n       = '0;
        emit_done    = 1'b0;
        emit_last    = 1'b0;
        emit_ret     = ST_IDLE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = pixel & pixel_mask(bpp);
                    end_next   = row_end;
                    state_next = ST_STEP;
                end
            end

            ST_STEP:
            begin
                if (count_reg == '0)
                begin
                    // new row or after a row end: the pixel opens a literal as lookahead
                    held_next  = x_reg;
                    count_next = CNT_W'(1);
                    run_next   = 1'b0;
                    state_next = after_step;
                end
                else if (run_reg)
                begin
                    if (eq && (count_reg < MAX_C))
                    begin
                        count_next = count_reg + CNT_W'(1);
                        state_next = after_step;
                    end
                    else if (out_free)
                    begin
                        push                 = 1'b1;
                        push_res.has_header  = 1'b1;
                        push_res.header      = HDR_RUN | {1'b0, cnt_m1[6:0]};
                        push_res.pixel_count = 3'd1;
                        push_res.pix[0]      = held_reg;
                        push_res.step_last   = !end_reg;
                        run_next             = 1'b0;
                        count_next           = CNT_W'(1);
                        held_next            = x_reg;
                        state_next           = after_step;
                    end
                end
                else if (lit == MAX_C)
                begin
                    // full literal: flush it, then look at this pixel again
                    emit_go    = 1'b1;
                    emit_n     = MAX_C;
                    emit_last  = !end_reg;
                    emit_ret   = ST_STEP;
                    count_next = CNT_W'(1);
                end
                else if (eq)
                begin
                    run_next   = 1'b1;
                    count_next = CNT_W'(2);
                    if (lit != '0)
                    begin
                        emit_go   = 1'b1;
                        emit_n    = lit;
                        emit_last = !end_reg;
                        emit_ret  = after_step;
                    end
                    else
                    begin
                        state_next = after_step;
                    end
                end
                else
                begin
                    sreq.wr_en   = 1'b1;
                    sreq.wr_addr = lit;
                    sreq.wr_data = held_reg;
                    held_next    = x_reg;
                    count_next   = count_reg + CNT_W'(1);
                    state_next   = after_step;
                end
            end

            ST_END:
            begin
                if (run_reg)
                begin
                    if (out_free)
                    begin
                        push                 = 1'b1;
                        push_res.has_header  = 1'b1;
                        push_res.header      = HDR_RUN | {1'b0, cnt_m1[6:0]};
                        push_res.pixel_count = 3'd1;
                        push_res.pix[0]      = held_reg;
                        push_res.row_done    = 1'b1;
                        push_res.step_last   = 1'b1;
                        run_next             = 1'b0;
                        count_next           = '0;
                        state_next           = ST_IDLE;
                    end
                end
                else if (lit == MAX_C)
                begin
                    emit_go    = 1'b1;
                    emit_n     = MAX_C;
                    emit_ret   = ST_END;
                    count_next = CNT_W'(1);
                end
                else
                begin
                    // commit the lookahead pixel and close the row's literal
                    sreq.wr_en   = 1'b1;
                    sreq.wr_addr = lit;
                    sreq.wr_data = held_reg;
                    emit_go      = 1'b1;
                    emit_n       = count_reg;
                    emit_done    = 1'b1;
                    emit_last    = 1'b1;
                    emit_ret     = ST_IDLE;
                    count_next   = '0;
                    run_next     = 1'b0;
                end
            end

            ST_LIT_RD:
            begin
                sreq.rd_en   = 1'b1;
                sreq.rd_addr = pos_reg;
                rd_vld_next  = 1'b1;
                rd_slot_next = slot_reg;
                pos_next     = pos_reg + CNT_W'(1);
                if ((slot_reg == SLOT_L) || (pos_next == n_reg))
                begin
                    state_next = ST_LIT_PUSH;
                end
                else
                begin
                    slot_next = slot_reg + SW'(1);
                end
            end

            ST_LIT_PUSH:
            begin
                push_res.has_header  = first_reg;
                push_res.header      = first_reg ? {1'b0, n_m1[6:0]} : 8'd0;
                push_res.pixel_count = 3'(slot_reg) + 3'd1;
                for (int k = 0; k < PIXELS_PER_RESULT; k++)
                begin
                    if (SW'(k) <= slot_reg)
                    begin
                        push_res.pix[k] = (rd_vld_reg && (rd_slot_reg == SW'(k)))
                                          ? rd_data : build_reg[k];
                    end
                end
                push_res.row_done  = last_chunk && done_reg;
                push_res.step_last = last_chunk && last_reg;
                if (out_free)
                begin
                    push = 1'b1;
                    if (last_chunk)
                    begin
                        state_next = ret_reg;
                    end
                    else
                    begin
                        first_next = 1'b0;
                        slot_next  = '0;
                        state_next = ST_LIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit_go)
        begin
            n_next     = emit_n;
            pos_next   = '0;
            first_next = 1'b1;
            slot_next  = '0;
            done_next  = emit_done;
            last_next  = emit_last;
            ret_next   = emit_ret;
            state_next = ST_LIT_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            end_reg     <= 1'b0;
            count_reg   <= '0;
            run_reg     <= 1'b0;
            held_reg    <= '0;
            n_reg       <= '0;
            pos_reg     <= '0;
            first_reg   <= 1'b0;
            slot_reg    <= '0;
            done_reg    <= 1'b0;
            last_reg    <= 1'b0;
            rd_vld_reg  <= 1'b0;
            rd_slot_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            end_reg     <= end_next;
            count_reg   <= count_next;
            run_reg     <= run_next;
            held_reg    <= held_next;
            n_reg       <= n_next;
            pos_reg     <= pos_next;
            first_reg   <= first_next;
            slot_reg    <= slot_next;
            done_reg    <= done_next;
            last_reg    <= last_next;
            rd_vld_reg  <= rd_vld_next;
            rd_slot_reg <= rd_slot_next;
        end
    end

    // payload: incoming pixel and the pixels gathered for the current result
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (rd_vld_reg)
        begin
            build_reg[rd_slot_reg] <= rd_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pixel_rle_packet_encoder.sv
// pixel_rle_packet_encoder: top level of the run-length packet encoder
// depends on prle_pkg, prle_store, prle_outreg and prle_ctrl
//
//   channel   direction  handshake             payload
//   in        request    in_valid / in_stall   pixel, row_end
//   out       result     out_valid / out_stall has_header, header, pixel_count,
//                                              pixel_a..pixel_d, row_done, step_last
//   cfg       write      cfg_wr_en             cfg_wr_data (bytes_per_pixel)
//
// a request that closes no packet is accepted, then updates the open packet
// a run packet leaves in the update cycle; a literal of n pixels adds one store read
// per pixel and one push per result
// a full literal leaving ahead of the new pixel adds one more update; a row end adds
// a close of the open packet, and up to two packets leave then
// in_stall is high while a request is worked; a result waits on a full, stalled output register
// reset clears the open packet and sets the width to one byte; the store needs no clearing
`default_nettype none

module pixel_rle_packet_encoder
    import prle_pkg::*;
#(
    parameter int MAX_PACKET        = 128,
    parameter int PIXELS_PER_RESULT = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_wr_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [31:0]        pixel,
    input  wire logic               row_end,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    has_header,
    output logic [7:0]              header,
    output logic [2:0]              pixel_count,
    output logic [31:0]             pixel_a,
    output logic [31:0]             pixel_b,
    output logic [31:0]             pixel_c,
    output logic [31:0]             pixel_d,
    output logic                    row_done,
    output logic                    step_last
);

    // bytes per pixel; out of range codes are folded when the mask is built
    logic [2:0]       bpp_reg;

    store_req_t       sreq;
    logic [PIX_W-1:0] rd_data;
    logic             out_free;
    logic             push;
    result_t          push_res;
    result_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= 3'd1;
        end
        else if (cfg_wr_en)
        begin
            bpp_reg <= cfg_wr_data;
        end
    end

    // sequencer: open packet state, lookahead compare, literal walk
    prle_ctrl #(
        .MAX_PACKET        (MAX_PACKET),
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .bpp      (bpp_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pixel    (pixel),
        .row_end  (row_end),
        .sreq     (sreq),
        .rd_data  (rd_data),
        .out_free (out_free),
        .push     (push),
        .push_res (push_res)
    );

    // literal pixels wait here until their packet closes
    prle_store #(
        .MAX_PACKET (MAX_PACKET)
    ) u_store (
        .clk     (clk),
        .req     (sreq),
        .rd_data (rd_data)
    );

    // result register parts the sequencer from the result channel
    prle_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign has_header  = res.has_header;
    assign header      = res.header;
    assign pixel_count = res.pixel_count;
    assign pixel_a     = res.pix[0];
    assign pixel_b     = res.pix[1];
    assign pixel_c     = res.pix[2];
    assign pixel_d     = res.pix[3];
    assign row_done    = res.row_done;
    assign step_last   = res.step_last;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for pixel_rle_packet_encoder
// streams pixel rows through the encoder and checks every packet result against
// a cycle-free packet predictor; depends on prle_pkg and the encoder rtl
`default_nettype none

module tb_top
    import prle_pkg::*;
();

    // packet limits of the encoder as built here
    localparam int PACKET_MAX    = 128;
    localparam int PIX_PER_WORD  = 4;
    // cycles with no request and no result taken before the run is declared hung
    localparam int HANG_LIMIT    = 3000;
    // quiet cycles after the last result before touching the width register
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 9;
    // minimum random pixels per random phase, on top of the long row in the first phase
    localparam int PHASE_PIXELS  = 4;

    typedef enum int {
        SEG_RUN,
        SEG_LITERAL,
        SEG_NOISE
    } segment_kind_t;

    // one pixel request waiting for the driver
    typedef struct packed {
        bit [PIX_W-1:0] value;
        bit             closes_row;
    } pixel_req_t;

    // one expected result word on the output channel
    typedef struct packed {
        bit                             has_header;
        bit [7:0]                       header;
        bit [2:0]                       pixel_count;
        bit [NUM_PIX-1:0][PIX_W-1:0]    px;
        bit                             row_done;
        bit                             step_last;
    } packet_word_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_wr_en = 1'b0;
    logic [2:0]     cfg_wr_data = 3'd0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    logic [31:0]    pixel = 32'd0;
    logic           row_end = 1'b0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    logic           has_header;
    logic [7:0]     header;
    logic [2:0]     pixel_count;
    logic [31:0]    pixel_a;
    logic [31:0]    pixel_b;
    logic [31:0]    pixel_c;
    logic [31:0]    pixel_d;
    logic           row_done;
    logic           step_last;

    pixel_rle_packet_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .row_end     (row_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .has_header  (has_header),
        .header      (header),
        .pixel_count (pixel_count),
        .pixel_a     (pixel_a),
        .pixel_b     (pixel_b),
        .pixel_c     (pixel_c),
        .pixel_d     (pixel_d),
        .row_done    (row_done),
        .step_last   (step_last)
    );

    // stimulus and expectation stores
    pixel_req_t     pixel_requests[$];
    packet_word_t   expected_words[$];

    // predictor copy of the encoder state
    bit [PIX_W-1:0] lit_store [PACKET_MAX];
    int             open_count;
    bit             open_run;
    bit [PIX_W-1:0] held;
    bit [2:0]       cur_bpp;

    // generator state
    bit [PIX_W-1:0] gen_mask;
    bit [PIX_W-1:0] gen_prev;

    // idling control, cleared for every third phase and for the last phase
    bit             gaps_on;
    int             send_gap;
    int             recv_gap;

    int unsigned    requests_queued;
    int unsigned    requests_accepted;
    int unsigned    results_checked;
    int unsigned    rows_closed;
    int unsigned    mismatches;
    int unsigned    stuck_cycles;
    bit [7:0]       widths_written;

    pixel_req_t     next_req;
    bit             take_next;
    packet_word_t   want;

    // ------------------------------------------------------------------
    // packet predictor
    // ------------------------------------------------------------------

    // low bytes that count for a width code; zero acts as one, above four as four
    function automatic bit [PIX_W-1:0] width_mask(bit [2:0] code);
        case (code)
            3'd0, 3'd1: return 32'h0000_00FF;
            3'd2:       return 32'h0000_FFFF;
            3'd3:       return 32'h00FF_FFFF;
            default:    return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic void push_run_packet(int n, bit [PIX_W-1:0] value);
        packet_word_t w;
        w = '0;
        w.has_header  = 1'b1;
        w.header      = HDR_RUN | (8'(n - 1) & 8'h7F);
        w.pixel_count = 3'd1;
        w.px[0]       = value;
        expected_words.push_back(w);
    endfunction

    // literal leaves in words of up to four pixels, header on the first word only
    function automatic void push_literal_packet(int n);
        packet_word_t w;
        int pos;
        int chunk;
        bit first;
        if (n > PACKET_MAX)
            n = PACKET_MAX;
        pos = 0;
        first = 1'b1;
        while (pos < n) begin
            chunk = n - pos;
            if (chunk > PIX_PER_WORD)
                chunk = PIX_PER_WORD;
            w = '0;
            w.has_header  = first;
            w.header      = first ? (8'(n - 1) & 8'h7F) : 8'h00;
            w.pixel_count = 3'(chunk);
            for (int i = 0; i < chunk; i++)
                w.px[i] = lit_store[pos + i];
            expected_words.push_back(w);
            first = 1'b0;
            pos += chunk;
        end
    endfunction

    // one accepted pixel: update the open packet and queue what it closes
    function automatic void encode_pixel(bit [PIX_W-1:0] raw, bit last);
        bit [PIX_W-1:0] x;
        int lit;
        int size_on_entry;
        x = raw & width_mask(cur_bpp);
        size_on_entry = expected_words.size();
        if (open_count == 0) begin
            open_run   = 1'b0;
            open_count = 1;
            held       = x;
        end else if (open_run) begin
            if (x == held && open_count < PACKET_MAX) begin
                open_count++;
            end else begin
                push_run_packet(open_count, held);
                open_run   = 1'b0;
                open_count = 1;
                held       = x;
            end
        end else begin
            lit = open_count - 1;
            // a full literal leaves before the new pixel is looked at
            if (lit >= PACKET_MAX) begin
                push_literal_packet(lit);
                lit = 0;
            end
            if (held == x) begin
                if (lit > 0)
                    push_literal_packet(lit);
                open_run   = 1'b1;
                open_count = 2;
            end else begin
                lit_store[lit] = held;
                lit++;
                held       = x;
                open_count = lit + 1;
            end
        end
        if (last) begin
            if (open_run) begin
                push_run_packet(open_count, held);
            end else begin
                lit = open_count - 1;
                if (lit >= PACKET_MAX) begin
                    push_literal_packet(lit);
                    lit = 0;
                end
                lit_store[lit] = held;
                push_literal_packet(lit + 1);
            end
            open_count = 0;
            open_run   = 1'b0;
            rows_closed++;
        end
        if (expected_words.size() > size_on_entry) begin
            expected_words[expected_words.size() - 1].step_last = 1'b1;
            if (last)
                expected_words[expected_words.size() - 1].row_done = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_pixel(bit [PIX_W-1:0] value, bit closes);
        pixel_requests.push_back('{value: value, closes_row: closes});
        gen_prev = value;
        requests_queued++;
    endtask

    // random pixel that differs from prev in the bytes that count
    function automatic bit [PIX_W-1:0] differing_pixel(bit [PIX_W-1:0] prev);
        bit [PIX_W-1:0] p;
        p = $urandom;
        while ((p & gen_mask) == (prev & gen_mask))
            p = $urandom;
        return p;
    endfunction

    // equal to v in the bytes that count, random above them
    function automatic bit [PIX_W-1:0] same_pixel(bit [PIX_W-1:0] v);
        bit [PIX_W-1:0] noise;
        noise = $urandom;
        return (v & gen_mask) | (noise & ~gen_mask);
    endfunction

    // a row built from runs, distinct stretches and noise from a tiny alphabet
    task automatic queue_random_row(int row_len, bit closes);
        bit [PIX_W-1:0] alphabet [3];
        bit [PIX_W-1:0] v;
        segment_kind_t kind;
        int left;
        int seg;
        for (int i = 0; i < 3; i++)
            alphabet[i] = $urandom;
        left = row_len;
        while (left > 0) begin
            seg = $urandom_range(1, 6);
            if (seg > left)
                seg = left;
            kind = segment_kind_t'($urandom_range(0, 2));
            v = differing_pixel(gen_prev);
            for (int i = 0; i < seg; i++) begin
                case (kind)
                    SEG_RUN:     queue_pixel(same_pixel(v), closes && left == 1);
                    SEG_LITERAL: queue_pixel(differing_pixel(gen_prev), closes && left == 1);
                    default:     queue_pixel(alphabet[$urandom_range(0, 2)],
                                             closes && left == 1);
                endcase
                left--;
            end
        end
    endtask

    // rows that cross the packet limit
    // run_first: a run one past the limit, then a full literal that flushes at the row end
    // otherwise: a literal one past the limit, then a row-closing pixel that flushes it
    task automatic queue_long_row(bit run_first);
        bit [PIX_W-1:0] v;
        if (run_first) begin
            v = differing_pixel(gen_prev);
            for (int i = 0; i <= PACKET_MAX; i++)
                queue_pixel(same_pixel(v), 1'b0);
            for (int i = 0; i < PACKET_MAX; i++)
                queue_pixel(differing_pixel(gen_prev), i == PACKET_MAX - 1);
        end else begin
            for (int i = 0; i <= PACKET_MAX; i++)
                queue_pixel(differing_pixel(gen_prev), 1'b0);
            if ($urandom_range(0, 1) == 1)
                queue_pixel(same_pixel(gen_prev), 1'b1);
            else
                queue_pixel(differing_pixel(gen_prev), 1'b1);
        end
    endtask

    // block idle: every request taken, every result back, then a few quiet cycles
    task automatic settle_block;
        while (requests_accepted != requests_queued)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // width register write; only called while the block is idle
    task automatic write_width(bit [2:0] code);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_bpp  = code;
        gen_mask = width_mask(code);
        widths_written[code] = 1'b1;
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // request driver: presents queued pixels, holds them while stalled,
    // predicts on every accepted request, inserts random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            pixel    <= 32'd0;
            row_end  <= 1'b0;
            send_gap <= 0;
        end else begin
            take_next = 1'b0;
            if (in_valid && !in_stall) begin
                // request taken at this edge
                encode_pixel(pixel, row_end);
                requests_accepted++;
                if (gaps_on && $urandom_range(0, 5) == 0) begin
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 13);
                end else begin
                    take_next = 1'b1;
                end
            end else if (!in_valid) begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else
                    take_next = 1'b1;
            end
            // a stalled request just stays on the port
            if (take_next) begin
                if (pixel_requests.size() > 0) begin
                    next_req = pixel_requests.pop_front();
                    in_valid <= 1'b1;
                    pixel    <= next_req.value;
                    row_end  <= next_req.closes_row;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks each taken result against the oldest
    // expectation, and drives out_stall in random bursts
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            recv_gap  <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                results_checked++;
                if (expected_words.size() == 0) begin
                    $error("result with nothing expected: header %0h, pixel_count %0d",
                           header, pixel_count);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("has_header", 32'(want.has_header), 32'(has_header));
                    check_field("header", 32'(want.header), 32'(header));
                    check_field("pixel_count", 32'(want.pixel_count), 32'(pixel_count));
                    check_field("pixel_a", want.px[0], pixel_a);
                    check_field("pixel_b", want.px[1], pixel_b);
                    check_field("pixel_c", want.px[2], pixel_c);
                    check_field("pixel_d", want.px[3], pixel_d);
                    check_field("row_done", 32'(want.row_done), 32'(row_done));
                    check_field("step_last", 32'(want.step_last), 32'(step_last));
                end
            end
            // stall bursts of random length
            if (recv_gap > 0) begin
                out_stall <= 1'b1;
                recv_gap  <= recv_gap - 1;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                recv_gap  <= $urandom_range(0, 13);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // hang watchdog: counts cycles in which neither channel moves
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= HANG_LIMIT);
        $display("no progress for %0d cycles, %0d results still expected",
                 HANG_LIMIT, expected_words.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int row_len;
        int placed;
        bit leave_open;
        bit [2:0] code;

        open_count = 0;
        open_run   = 1'b0;
        held       = '0;
        cur_bpp    = 3'd1;
        gen_mask   = width_mask(3'd1);
        gen_prev   = '0;
        gaps_on    = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows at the reset width of one byte
        // single pixel row: literal of one
        queue_pixel(32'h0000_0000, 1'b1);
        // all ones: run of three, upper bytes dropped
        queue_pixel(32'hFFFF_FFFF, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b1);
        // pixels that differ only above the width form a run
        queue_pixel(32'h1234_5600, 1'b0);
        queue_pixel(32'hABCD_EF00, 1'b1);
        // literal closed by a pair, run of three, lone pixel at the row end
        queue_pixel(32'h0000_0001, 1'b0);
        queue_pixel(32'h0000_0002, 1'b0);
        queue_pixel(32'h0000_0003, 1'b0);
        queue_pixel(32'h0000_0003, 1'b0);
        queue_pixel(32'h0000_0003, 1'b0);
        queue_pixel(32'h0000_0004, 1'b1);
        // quiet requests, row left open across a width change
        queue_pixel(32'h0000_0107, 1'b0);
        queue_pixel(32'h0000_0108, 1'b0);
        settle_block();

        // two bytes: held pixels keep their one-byte value
        write_width(3'd2);
        queue_pixel(32'h0000_0108, 1'b0);
        queue_pixel(32'hFFFF_0108, 1'b1);
        queue_pixel(32'hFFFF_FFFF, 1'b1);
        settle_block();

        // code zero behaves as one byte
        write_width(3'd0);
        queue_pixel(32'h0000_01FF, 1'b0);
        queue_pixel(32'h0000_02FF, 1'b1);
        settle_block();

        // code seven behaves as four bytes
        write_width(3'd7);
        queue_pixel(32'hFFFF_FFFF, 1'b0);
        queue_pixel(32'h7FFF_FFFF, 1'b1);
        settle_block();

        // random phases, one width setting each; the sender drains between them
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       code = 3'd3;
                1:       code = 3'd4;
                2:       code = 3'd5;
                3:       code = 3'd6;
                4:       code = 3'd1;
                5:       code = 3'd2;
                6:       code = 3'd0;
                7:       code = 3'd7;
                default: code = 3'($urandom_range(0, 7));
            endcase
            write_width(code);
            // every third phase runs without gaps, and the last one too
            gaps_on = (p % 3 != 2) && (p != RANDOM_PHASES - 1);
            if (p == 0)
                queue_long_row(1'b1);
            placed = 0;
            while (placed < PHASE_PIXELS) begin
                if ($urandom_range(0, 5) == 0)
                    row_len = $urandom_range(13, 24);
                else
                    row_len = $urandom_range(1, 8);
                // some phases end mid-row so the next width applies to an open row
                leave_open = (p % 3 == 1) && (placed + row_len >= PHASE_PIXELS);
                queue_random_row(row_len, !leave_open);
                placed += row_len;
            end
            settle_block();
        end

        $display("sent %0d pixel requests in %0d rows, checked %0d results",
                 requests_accepted, rows_closed, results_checked);
        $display("width codes written: %b, runs and literals past the packet limit included",
                 widths_written);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/prle_pkg.sv
rtl/prle_store.sv
rtl/prle_outreg.sv
rtl/prle_ctrl.sv
rtl/pixel_rle_packet_encoder.sv
tb/tb_top.sv
